// ===== src/led_blink_pixel_sequencer_macros.svh =====
// ---------------------------------------------------------------------------
// LED blink pixel sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef LED_BLINK_PIXEL_SEQUENCER_MACROS_SVH
`define LED_BLINK_PIXEL_SEQUENCER_MACROS_SVH

// property must hold at every clock edge out of reset
`define LBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define LBPS_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/lbps_pkg.sv =====
// ---------------------------------------------------------------------------
// LED blink pixel sequencer package
// Shared types, constants and the event color table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbps_pkg;

  localparam int LED_COUNT_DEF = 16;
  localparam int KIND_COUNT    = 13;
  localparam int RND_W         = 16;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_ON    = 2'd2,
    PH_OFF   = 2'd3
  } phase_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_BASE_RED    = 3'd0,
    REG_BASE_GREEN  = 3'd1,
    REG_BASE_BLUE   = 3'd2,
    REG_START_DELAY = 3'd3,
    REG_ON_TIME     = 3'd4,
    REG_OFF_TIME    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] deadline;
    logic [23:0] color;
  } led_t;

  function automatic logic [23:0] kind_color(input logic [3:0] kind);
    logic [23:0] c;
    case (kind)
      4'd0:    c = 24'h141464;
      4'd1:    c = 24'h0A1E3C;
      4'd2:    c = 24'h00283C;
      4'd3:    c = 24'h00003C;
      4'd4:    c = 24'h003C64;
      4'd5:    c = 24'h641414;
      4'd6:    c = 24'h146414;
      4'd7:    c = 24'h003C28;
      4'd8:    c = 24'h003C14;
      4'd9:    c = 24'h645000;
      4'd10:   c = 24'h141414;
      4'd11:   c = 24'h646464;
      4'd12:   c = 24'h646464;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

// ===== src/lbps_cell.sv =====
// ---------------------------------------------------------------------------
// LED state cell
// Holds one LED's phase, deadline and color; loads from its neighbor on shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbps_cell
  import lbps_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic shift_en,
  input  led_t led_in,
  output led_t led_out
);

  led_t led_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r.phase    <= PH_IDLE;
      led_r.deadline <= '0;
      led_r.color    <= '0;
    end else if (shift_en) begin
      led_r <= led_in;
    end
  end

  assign led_out = led_r;

endmodule

// ===== src/lbps_mod.sv =====
// ---------------------------------------------------------------------------
// Iterative remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder only.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbps_mod
  import lbps_pkg::*;
#(
  parameter int DVS_W = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVS_W-1:0] remainder
);

  localparam int STEP_W = $clog2(RND_W + 1);

  logic [RND_W-1:0]  dvd_r, dvd_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DVS_W:0]    trial;

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, dvd_r[RND_W-1]};
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract where the divisor fits
      dvd_nxt = {dvd_r[RND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = DVS_W'(trial - {1'b0, divisor});
      end else begin
        rem_nxt = trial[DVS_W-1:0];
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(RND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== src/led_blink_pixel_sequencer.sv =====
// ---------------------------------------------------------------------------
// LED blink pixel sequencer
// Ring of LED state cells with a tick pass and a talk pick, stream ports.
// ---------------------------------------------------------------------------
// The LED states sit in a ring of LED_COUNT cells that rotates one place per
// cycle while a pass runs and the output is not held off by out_tready, past a
// single update point at the head. A tick beat (tuser = 0) makes one full
// rotation and emits one color beat per LED in index order, tlast on the final
// one; the ring holds while out_tready holds off the output. A talk beat
// (tuser = 1) takes one rotation to count idle LEDs, then a pass through the
// serial remainder unit, then a second rotation to start the picked LED; when
// no LED is idle it ends after the first rotation. One input beat is worked
// on at a time. Registers may be written through the cfg port whenever the
// block is idle.
`timescale 1ns / 1ps

module led_blink_pixel_sequencer
  import lbps_pkg::*;
#(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // now_time[31:0], event_kind[35:32], random_value[51:36], zero fill
  input  logic [55:0]           in_tdata,
  // action
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // led_index[3:0], led_red[11:4], led_green[19:12], led_blue[27:20]
  output logic [31:0]           out_tdata,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "led_blink_pixel_sequencer_macros.svh"

  localparam int IW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int CW = $clog2(LED_COUNT + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TICK  = 5'b00010,
    S_COUNT = 5'b00100,
    S_DIV   = 5'b01000,
    S_PICK  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [7:0]  base_red_r, base_green_r, base_blue_r;
  logic [15:0] start_delay_r, on_time_r, off_time_r;

  logic [31:0]      now_r;
  logic [3:0]       kind_r;
  logic [RND_W-1:0] rnd_r;

  logic [IW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] pick_r, pick_nxt;
  logic          hit_r, hit_nxt;

  logic          out_valid_r;
  logic [31:0]   out_data_r;
  logic          out_last_r;
  logic          out_free;
  logic          out_load;

  led_t          cell_q [LED_COUNT];
  led_t          head, head_nxt;
  logic          shift_en;
  logic [23:0]   shown;
  logic [23:0]   base_col;
  logic          due;
  logic          last_pos;
  logic [IW+3:0] idx_ext;

  logic          div_start, div_done;
  logic [CW-1:0] div_rem;

  // ring of cells: each loads from the next, the tail from the head update
  for (genvar g = 0; g < LED_COUNT; g++) begin : g_cell
    led_t cin;
    if (g == LED_COUNT - 1) begin : g_tail
      assign cin = head_nxt;
    end else begin : g_mid
      assign cin = cell_q[g+1];
    end
    lbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .led_in   (cin),
      .led_out  (cell_q[g])
    );
  end

  lbps_mod #(.DVS_W(CW)) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (rnd_r),
    .divisor   (cnt_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  assign head     = cell_q[0];
  assign base_col = {base_red_r, base_green_r, base_blue_r};
  assign due      = now_r >= head.deadline;
  assign last_pos = pos_r == IW'(LED_COUNT - 1);
  assign out_free = !out_valid_r || out_tready;
  assign idx_ext  = {4'b0000, pos_r};

  // head update for the beat in flight
  always_comb begin
    head_nxt = head;
    shown    = 24'h000000;
    case (state_r)
      S_TICK: begin
        case (head.phase)
          PH_START: begin
            if (due) begin
              head_nxt.phase    = PH_ON;
              head_nxt.deadline = now_r + {16'h0000, on_time_r};
            end
          end
          PH_ON: begin
            shown = head.color;
            if (due) begin
              head_nxt.phase    = PH_OFF;
              head_nxt.deadline = now_r + {16'h0000, off_time_r};
            end
          end
          PH_OFF: begin
            if (due) begin
              head_nxt.phase    = PH_IDLE;
              head_nxt.deadline = '0;
              head_nxt.color    = base_col;
            end
          end
          default: shown = base_col;
        endcase
      end
      S_PICK: begin
        if (head.phase == PH_IDLE && pick_r == '0 && !hit_r) begin
          head_nxt.phase    = PH_START;
          head_nxt.deadline = now_r + {16'h0000, start_delay_r};
          if (kind_r < 4'(KIND_COUNT)) begin
            head_nxt.color = kind_color(kind_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    pick_nxt  = pick_r;
    hit_nxt   = hit_r;
    shift_en  = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    case (state_r)
      S_IDLE: begin
        pos_nxt = '0;
        if (in_tvalid) begin
          if (in_tuser) begin
            cnt_nxt   = '0;
            state_nxt = S_COUNT;
          end else begin
            state_nxt = S_TICK;
          end
        end
      end
      S_TICK: begin
        // hold the ring while the output beat waits
        if (out_free) begin
          shift_en = 1'b1;
          out_load = 1'b1;
          pos_nxt  = pos_r + 1'b1;
          if (last_pos) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_COUNT: begin
        shift_en = 1'b1;
        pos_nxt  = pos_r + 1'b1;
        if (head.phase == PH_IDLE) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (last_pos) begin
          pos_nxt = '0;
          if (cnt_nxt == '0) begin
            state_nxt = S_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        hit_nxt = 1'b0;
        if (div_done) begin
          pick_nxt  = div_rem;
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        shift_en = 1'b1;
        pos_nxt  = pos_r + 1'b1;
        if (head.phase == PH_IDLE && !hit_r) begin
          if (pick_r == '0) begin
            hit_nxt = 1'b1;
          end else begin
            pick_nxt = pick_r - 1'b1;
          end
        end
        if (last_pos) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      pick_r      <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      pick_r  <= pick_nxt;
      hit_r   <= hit_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {4'h0, shown[7:0], shown[15:8], shown[23:16], idx_ext[3:0]};
      out_last_r <= last_pos;
    end
    if (state_r == S_IDLE && in_tvalid) begin
      now_r  <= in_tdata[31:0];
      kind_r <= in_tdata[35:32];
      rnd_r  <= in_tdata[51:36];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_red_r    <= 8'd0;
      base_green_r  <= 8'd0;
      base_blue_r   <= 8'd0;
      start_delay_r <= 16'd100;
      on_time_r     <= 16'd200;
      off_time_r    <= 16'd200;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_BASE_RED:    base_red_r    <= cfg_wdata[7:0];
        REG_BASE_GREEN:  base_green_r  <= cfg_wdata[7:0];
        REG_BASE_BLUE:   base_blue_r   <= cfg_wdata[7:0];
        REG_START_DELAY: start_delay_r <= cfg_wdata;
        REG_ON_TIME:     on_time_r     <= cfg_wdata;
        REG_OFF_TIME:    off_time_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `LBPS_ASSERT(a_onehot_state, $onehot(state_r), "state register not one-hot")
  `LBPS_ASSERT(a_beat_from_tick, $rose(out_tvalid) |-> $past(state_r == S_TICK),
               "output beat raised outside a tick pass")
  `LBPS_NEVER(a_pick_once, state_r == S_PICK && hit_r && head_nxt.phase != head.phase,
              "talk started more than one LED")
  `LBPS_ASSERT(a_div_nonzero, div_start |-> cnt_nxt != '0, "remainder started with zero idle count")

endmodule

// ===== sim/tb.sv =====
// ---------------------------------------------------------------------------
// LED blink pixel sequencer testbench
// Drives tick and talk beats with random gaps on both stream sides, tracks
// every LED's phase, deadline and color in a local shadow and checks each
// color beat against it. Register settings change between drained phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lbps_pkg::*;

  localparam int NLED        = 16;
  localparam int ITEMS_PHASE = 38;
  localparam int SETTLE      = 60;
  localparam int CYCLE_LIMIT = 2000000;

  localparam logic [23:0] KIND_RGB [KIND_COUNT] = '{
    24'h141464, 24'h0A1E3C, 24'h00283C, 24'h00003C, 24'h003C64,
    24'h641414, 24'h146414, 24'h003C28, 24'h003C14, 24'h645000,
    24'h141414, 24'h646464, 24'h646464
  };

  typedef struct packed {
    logic [3:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct {
    logic        talk;
    logic [31:0] now;
    logic [3:0]  kind;
    logic [15:0] rnd;
    logic        known;
    logic [23:0] rgb;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tlast;
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the LED ring and the registers
  phase_t      sh_phase [NLED];
  logic [31:0] sh_due   [NLED];
  logic [23:0] sh_color [NLED];
  logic [7:0]  sh_red, sh_green, sh_blue;
  logic [15:0] sh_start, sh_on, sh_off;

  pixel_t pending_pixels[$];
  int     mismatches = 0;
  int     pixels_seen = 0;
  int     ticks_sent = 0;
  int     talks_sent = 0;
  int     cycles = 0;
  bit     no_gaps = 0;

  led_blink_pixel_sequencer dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels pending", cycles,
               pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic logic [23:0] base_rgb();
    return {sh_red, sh_green, sh_blue};
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NLED; i++) begin
      sh_phase[i] = PH_IDLE;
      sh_due[i]   = '0;
      sh_color[i] = '0;
    end
    sh_red = '0; sh_green = '0; sh_blue = '0;
    sh_start = 16'd100; sh_on = 16'd200; sh_off = 16'd200;
  endfunction

  function automatic void queue_pixel(int i, logic [23:0] rgb);
    pixel_t p;
    p.idx = i[3:0];
    {p.red, p.green, p.blue} = rgb;
    p.last = (i == NLED - 1);
    pending_pixels.push_back(p);
  endfunction

  // pick idle LED number rnd modulo the idle count and start it
  function automatic void talk_pick(logic [31:0] now, logic [3:0] kind,
                                    logic [15:0] rnd);
    int idle_cnt;
    int pick;
    idle_cnt = 0;
    for (int i = 0; i < NLED; i++) if (sh_phase[i] == PH_IDLE) idle_cnt++;
    if (idle_cnt == 0) return;
    pick = int'(rnd) % idle_cnt;
    for (int i = 0; i < NLED; i++) begin
      if (sh_phase[i] != PH_IDLE) continue;
      if (pick == 0) begin
        sh_phase[i] = PH_START;
        sh_due[i] = now + 32'(sh_start);
        if (kind < KIND_COUNT) sh_color[i] = KIND_RGB[kind];
        return;
      end
      pick--;
    end
  endfunction

  // emit pre-advance colors, then advance every LED whose deadline passed
  function automatic void tick_advance(logic [31:0] now, logic known,
                                       logic [23:0] rgb);
    logic [23:0] shown;
    logic due;
    for (int i = 0; i < NLED; i++) begin
      due = now >= sh_due[i];
      shown = '0;
      case (sh_phase[i])
        PH_START: if (due) begin
          sh_phase[i] = PH_ON;
          sh_due[i] = now + 32'(sh_on);
        end
        PH_ON: begin
          shown = sh_color[i];
          if (due) begin
            sh_phase[i] = PH_OFF;
            sh_due[i] = now + 32'(sh_off);
          end
        end
        PH_OFF: if (due) begin
          sh_phase[i] = PH_IDLE;
          sh_due[i] = '0;
          sh_color[i] = base_rgb();
        end
        default: shown = base_rgb();
      endcase
      queue_pixel(i, known ? rgb : shown);
    end
  endfunction

  // starts and ends at a falling edge; valid stays high across back-to-back beats
  task automatic send_step(step_row_t s);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= s.talk;
    in_tdata  <= {4'b0, s.rnd, s.kind, s.now};
    do @(posedge clk); while (!in_tready);
    if (s.talk) begin
      talk_pick(s.now, s.kind, s.rnd);
      talks_sent++;
    end else begin
      tick_advance(s.now, s.known, s.rgb);
      ticks_sent++;
    end
    @(negedge clk);
  endtask

  // wait out all pixels, then a talk that may still be rotating
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_BASE_RED:    sh_red   = val[7:0];
      REG_BASE_GREEN:  sh_green = val[7:0];
      REG_BASE_BLUE:   sh_blue  = val[7:0];
      REG_START_DELAY: sh_start = val;
      REG_ON_TIME:     sh_on    = val;
      default:         sh_off   = val;
    endcase
  endtask

  task automatic write_all(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [15:0] sd, logic [15:0] ont, logic [15:0] offt);
    write_reg(REG_BASE_RED, 16'(r));
    write_reg(REG_BASE_GREEN, 16'(g));
    write_reg(REG_BASE_BLUE, 16'(b));
    write_reg(REG_START_DELAY, sd);
    write_reg(REG_ON_TIME, ont);
    write_reg(REG_OFF_TIME, offt);
  endtask

  // result side: random hold-off per beat
  initial begin
    int gap;
    @(negedge clk);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      pixel_t got, want;
      got.idx   = out_tdata[3:0];
      got.red   = out_tdata[11:4];
      got.green = out_tdata[19:12];
      got.blue  = out_tdata[27:20];
      got.last  = out_tlast;
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        report($sformatf("unexpected pixel beat idx %0d", got.idx));
      end else begin
        want = pending_pixels.pop_front();
        if (got.idx != want.idx)
          report($sformatf("index %0d, want %0d", got.idx, want.idx));
        if (got.red != want.red)
          report($sformatf("led %0d red %0d, want %0d", want.idx, got.red, want.red));
        if (got.green != want.green)
          report($sformatf("led %0d green %0d, want %0d", want.idx, got.green,
                           want.green));
        if (got.blue != want.blue)
          report($sformatf("led %0d blue %0d, want %0d", want.idx, got.blue,
                           want.blue));
        if (got.last != want.last)
          report($sformatf("led %0d last %0b, want %0b", want.idx, got.last,
                           want.last));
      end
    end
  end

  initial begin
    step_row_t   steps[$];
    step_row_t   s;
    logic [31:0] clock_now;
    shadow_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: blank frame, every kind, full ring, wrap-range times
    steps.push_back('{1'b0, 32'h0, 4'h0, 16'h0, 1'b1, 24'h000000});
    for (int k = 0; k < 16; k++)
      steps.push_back('{1'b1, 32'(k), 4'(k), (k % 2) ? 16'hFFFF : 16'h0, 1'b0, 24'h0});
    steps.push_back('{1'b1, 32'h20, 4'h3, 16'h1234, 1'b0, 24'h0});  // no idle LED
    steps.push_back('{1'b0, 32'h50, 4'h0, 16'h0, 1'b0, 24'h0});     // nothing due yet
    steps.push_back('{1'b0, 32'hFFFF_FF80, 4'hF, 16'hFFFF, 1'b0, 24'h0});
    steps.push_back('{1'b0, 32'hFFFF_FFFF, 4'h0, 16'h0, 1'b0, 24'h0});
    steps.push_back('{1'b0, 32'hFFFF_FFFF, 4'h0, 16'h0, 1'b0, 24'h0});
    steps.push_back('{1'b0, 32'h0, 4'h0, 16'h0, 1'b0, 24'h0});
    foreach (steps[i]) send_step(steps[i]);
    drain();

    clock_now = 32'h0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(8'hFF, 8'hFF, 8'hFF, 16'h0, 16'h0, 16'h0);
        1: write_all(8'h00, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: write_all(8'hA5, 8'h5A, 8'h3C, 16'd1, 16'd2, 16'd3);
        default: write_all(8'($urandom), 8'($urandom), 8'($urandom),
                           16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                           16'($urandom_range(0, 400)));
      endcase
      no_gaps = (ph == 3);
      // ph 1 starts near the top so deadlines wrap past zero
      if (ph == 1) clock_now = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
      for (int n = 0; n < ITEMS_PHASE; n++) begin
        s.talk = ($urandom_range(0, 9) < 4);
        if ($urandom_range(0, 19) == 0) clock_now = $urandom;
        else clock_now += (ph == 1) ? $urandom_range(0, 40000) : $urandom_range(0, 300);
        s.now   = clock_now;
        s.kind  = 4'($urandom_range(0, 15));
        s.rnd   = 16'($urandom_range(0, 16'hFFFF));
        s.known = 1'b0;
        s.rgb   = '0;
        send_step(s);
      end
      drain();
    end

    $display("sent %0d ticks and %0d talks over 7 register settings", ticks_sent,
             talks_sent);
    $display("checked %0d pixel beats, %0d mismatches", pixels_seen, mismatches);
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== led_blink_pixel_sequencer.f =====
+incdir+src
src/lbps_pkg.sv
src/lbps_cell.sv
src/lbps_mod.sv
src/led_blink_pixel_sequencer.sv
sim/tb.sv
